@@ rtl/mfrb_pkg.sv @@
// ----------------------------------------------------------------------------
// mfrb_pkg
// Shared types and constants of the replicate-border 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrb_pkg;

    localparam int unsigned PIX_W         = 8;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned CFG_W         = 12;
    localparam int unsigned CFG_IDX_W     = 1;
    localparam int unsigned WIDTH_FIELD_W = 11;
    localparam int unsigned WINDOW        = 3;
    localparam int unsigned RING_ROWS     = WINDOW + 1;
    localparam int unsigned RING_W        = $clog2(RING_ROWS);
    localparam int unsigned MAX_WIDTH_DEF = 1024;
    localparam int unsigned MAX_HEIGHT    = 4095;
    localparam int unsigned MIN_SIZE      = 3;
    localparam int unsigned WIDTH_RESET   = 640;
    localparam int unsigned HEIGHT_RESET  = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    // One window column, sorted
    typedef struct packed {
        pix_t hi;
        pix_t mid;
        pix_t lo;
    } col_t;

    // Position of the output within its row
    typedef struct packed {
        logic first_col;
        logic last_col;
    } win_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mfrb_ram.sv @@
// ----------------------------------------------------------------------------
// mfrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/mfrb_median.sv @@
// ----------------------------------------------------------------------------
// mfrb_median
// Sorts the incoming window column and forms the 3x3 median from three
// sorted columns, replicating the edge column at row start and row end.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrb_median (
    input  wire mfrb_pkg::pix_t     pix0,
    input  wire mfrb_pkg::pix_t     pix1,
    input  wire mfrb_pkg::pix_t     pix2,
    input  wire mfrb_pkg::col_t     col_center,
    input  wire mfrb_pkg::col_t     col_left,
    input  wire mfrb_pkg::win_ctl_t ctl,
    output mfrb_pkg::col_t          col_new,
    output mfrb_pkg::pix_t          median
);

    function automatic mfrb_pkg::pix_t max2(input mfrb_pkg::pix_t a, input mfrb_pkg::pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic mfrb_pkg::pix_t min2(input mfrb_pkg::pix_t a, input mfrb_pkg::pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mfrb_pkg::pix_t med3(input mfrb_pkg::pix_t a, input mfrb_pkg::pix_t b,
                                            input mfrb_pkg::pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mfrb_pkg::col_t col_l;
    mfrb_pkg::col_t col_r;
    mfrb_pkg::pix_t lo_max;
    mfrb_pkg::pix_t mid_med;
    mfrb_pkg::pix_t hi_min;

    always_comb
    begin
        col_new.lo  = min2(min2(pix0, pix1), pix2);
        col_new.hi  = max2(max2(pix0, pix1), pix2);
        col_new.mid = med3(pix0, pix1, pix2);
    end

    // Replicate the center column past either image edge
    assign col_l = ctl.first_col ? col_center : col_left;
    assign col_r = ctl.last_col ? col_center : col_new;

    assign lo_max  = max2(max2(col_l.lo, col_center.lo), col_r.lo);
    assign mid_med = med3(col_l.mid, col_center.mid, col_r.mid);
    assign hi_min  = min2(min2(col_l.hi, col_center.hi), col_r.hi);
    assign median  = med3(lo_max, mid_med, hi_min);

endmodule

`default_nettype wire

@@ rtl/median_filter_replicate_border.sv @@
// ----------------------------------------------------------------------------
// median_filter_replicate_border
// Streaming 3x3 median filter with replicated border over a four-row ring of
// line stores; flush transactions drain the results still pending at frame end.
// ----------------------------------------------------------------------------
// Pipeline: a result is presented on m_tvalid after the input transaction that
// releases it passes the line-store read register, then the median and queue.
// Throughput: one transaction per clock while s_tready is high, set by one
// column read per line-store bank per cycle; a three-entry output queue absorbs
// output back-pressure. Reset: rst_n clears the position counters and queue and
// loads a 640x480 frame size; line-store contents are left as they are.
`default_nettype none

module median_filter_replicate_border #(
    parameter int unsigned MAX_WIDTH = mfrb_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] pixel
    input  wire logic                              s_tuser,   // [0] flush
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [7:0]                        m_tdata,   // [7:0] median_pixel
    output logic                                   m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [mfrb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [mfrb_pkg::CFG_W-1:0]        cfg_data
);

    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned DW = CW + 1;
    localparam int unsigned RW = mfrb_pkg::ROW_W;
    localparam int unsigned BW = mfrb_pkg::RING_W;
    localparam int unsigned NB = mfrb_pkg::RING_ROWS;
    localparam int unsigned W_RESET_I = (MAX_WIDTH < mfrb_pkg::WIDTH_RESET) ?
                                        MAX_WIDTH : mfrb_pkg::WIDTH_RESET;
    localparam logic [CW-1:0] W_RESET = CW'(W_RESET_I);
    localparam logic [CW-1:0] W_MAX   = CW'(MAX_WIDTH);
    localparam logic [RW-1:0] H_RESET = RW'(mfrb_pkg::HEIGHT_RESET);
    localparam logic [RW-1:0] H_MAX   = RW'(mfrb_pkg::MAX_HEIGHT);
    localparam logic [RW-1:0] H_MIN   = RW'(mfrb_pkg::MIN_SIZE);
    localparam int unsigned WV_W = (CW > mfrb_pkg::WIDTH_FIELD_W) ?
                                   CW : mfrb_pkg::WIDTH_FIELD_W;

    // frame size and position state
    logic [CW-1:0] w_reg, w_next;
    logic [RW-1:0] h_reg, h_next;
    logic [AW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [AW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [DW-1:0] dist_reg, dist_next;
    logic          primed_reg, primed_next;

    // read stage
    logic          s2_fire_reg;
    logic          s2_prime_reg;
    logic          s2_last_reg;
    mfrb_pkg::win_ctl_t s2_ctl_reg;
    logic [BW-1:0] s2_bank_reg [3];
    logic [2:0]    s2_byp_reg;
    mfrb_pkg::pix_t s2_pix_reg;

    mfrb_pkg::col_t col_a_reg;
    mfrb_pkg::col_t col_b_reg;

    // output queue
    mfrb_pkg::pix_t q_med_reg [3];
    logic [2:0]    q_last_reg;
    logic [1:0]    q_head_reg, q_tail_reg, q_cnt_reg;

    logic          accept;
    logic          complete, complete_n;
    logic          wr, fire, prime, last;
    logic          in_col_end, in_row_end, out_col_end, out_row_end;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;
    logic [DW-1:0] dist_w, lag;
    logic [RW-1:0] trow;
    logic [RW-1:0] tap_row [3];
    logic [BW-1:0] tap_bank [3];
    logic [2:0]    tap_byp;
    logic [AW-1:0] rcol;
    mfrb_pkg::pix_t ram_q [NB];
    mfrb_pkg::pix_t col_pix [3];
    mfrb_pkg::col_t col_new;
    mfrb_pkg::pix_t median;
    logic [WV_W:0] wv;
    logic          pop;

    assign accept = s_tvalid && s_tready;
    assign wm1    = w_reg - CW'(1);
    assign hm1    = h_reg - RW'(1);
    assign lag    = DW'(w_reg) + DW'(1);

    assign complete    = (in_row_reg == h_reg);
    assign wr          = accept && !complete && !s_tuser;
    assign in_col_end  = (CW'(in_col_reg) == wm1);
    assign in_row_end  = (in_row_reg == hm1);
    assign complete_n  = complete || (wr && in_col_end && in_row_end);
    assign dist_w      = dist_reg + DW'(wr);
    assign fire        = accept && (complete_n || (dist_w > lag));
    assign prime       = accept && !fire && wr && !primed_reg && (dist_w == lag);
    assign out_col_end = (CW'(out_col_reg) == wm1);
    assign out_row_end = (out_row_reg == hm1);
    assign last        = out_col_end && out_row_end;

    // At the end of a row, fetch the first column of the next row's window;
    // a prime fetches column 0 of the first window
    assign trow = (fire && out_col_end) ? out_row_reg + RW'(1) : out_row_reg;
    assign rcol = (!fire || out_col_end) ? '0 : out_col_reg + AW'(1);

    assign tap_row[0] = (trow == '0) ? '0 : trow - RW'(1);
    assign tap_row[1] = trow;
    assign tap_row[2] = (trow >= hm1) ? hm1 : trow + RW'(1);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tap_bank[k] = tap_row[k][BW-1:0];
            tap_byp[k]  = wr && (in_row_reg[BW-1:0] == tap_bank[k]) && (in_col_reg == rcol);
        end
    end

    for (genvar b = 0; b < NB; b++)
    begin : g_line
        mfrb_ram #(
            .WIDTH(mfrb_pkg::PIX_W),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .clk  (clk),
            .we   (wr && (in_row_reg[BW-1:0] == BW'(b))),
            .waddr(in_col_reg),
            .wdata(s_tdata),
            .raddr(rcol),
            .rdata(ram_q[b])
        );
    end

    assign wv = {{(WV_W + 1 - mfrb_pkg::WIDTH_FIELD_W){1'b0}},
                 cfg_data[mfrb_pkg::WIDTH_FIELD_W-1:0]};

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        dist_next    = dist_reg;
        primed_next  = primed_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                mfrb_pkg::REG_IMAGE_WIDTH:
                begin
                    if (wv < (WV_W + 1)'(mfrb_pkg::MIN_SIZE))
                        w_next = CW'(mfrb_pkg::MIN_SIZE);
                    else if (wv > (WV_W + 1)'(MAX_WIDTH))
                        w_next = W_MAX;
                    else
                        w_next = CW'(wv);
                end
                mfrb_pkg::REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data < H_MIN)
                        h_next = H_MIN;
                    else if (cfg_data > H_MAX)
                        h_next = H_MAX;
                    else
                        h_next = cfg_data;
                end
                default:
                begin
                    h_next = h_reg;
                end
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            dist_next    = '0;
            primed_next  = 1'b0;
        end
        else if (accept)
        begin
            if (wr)
            begin
                if (in_col_end)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + RW'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + AW'(1);
                end
            end
            if (fire && last)
            begin
                // restart the frame
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                dist_next    = '0;
                primed_next  = 1'b0;
            end
            else if (fire)
            begin
                dist_next = dist_w - DW'(1);
                if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
            else
            begin
                dist_next = dist_w;
                if (prime)
                    primed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= W_RESET;
            h_reg        <= H_RESET;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            dist_reg     <= '0;
            primed_reg   <= 1'b0;
            s2_fire_reg  <= 1'b0;
            s2_prime_reg <= 1'b0;
        end
        else
        begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            dist_reg     <= dist_next;
            primed_reg   <= primed_next;
            s2_fire_reg  <= fire;
            s2_prime_reg <= prime;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg          <= last;
        s2_ctl_reg.first_col <= (out_col_reg == '0);
        s2_ctl_reg.last_col  <= out_col_end;
        s2_byp_reg           <= tap_byp;
        s2_pix_reg           <= s_tdata;
        for (int k = 0; k < 3; k++)
        begin
            s2_bank_reg[k] <= tap_bank[k];
        end
    end

    // take the pixel being written when it is the one read back
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            col_pix[k] = s2_byp_reg[k] ? s2_pix_reg : ram_q[s2_bank_reg[k]];
        end
    end

    mfrb_median u_median (
        .pix0      (col_pix[0]),
        .pix1      (col_pix[1]),
        .pix2      (col_pix[2]),
        .col_center(col_a_reg),
        .col_left  (col_b_reg),
        .ctl       (s2_ctl_reg),
        .col_new   (col_new),
        .median    (median)
    );

    always_ff @(posedge clk)
    begin
        if (s2_fire_reg)
        begin
            col_b_reg <= col_a_reg;
            col_a_reg <= col_new;
        end
        else if (s2_prime_reg)
        begin
            col_a_reg <= col_new;
        end
        if (s2_fire_reg)
        begin
            q_med_reg[q_tail_reg]  <= median;
            q_last_reg[q_tail_reg] <= s2_last_reg;
        end
    end

    assign pop = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg <= '0;
            q_tail_reg <= '0;
            q_cnt_reg  <= '0;
        end
        else
        begin
            if (s2_fire_reg)
                q_tail_reg <= (q_tail_reg == 2'd2) ? 2'd0 : q_tail_reg + 2'd1;
            if (pop)
                q_head_reg <= (q_head_reg == 2'd2) ? 2'd0 : q_head_reg + 2'd1;
            q_cnt_reg <= q_cnt_reg + 2'(s2_fire_reg) - 2'(pop);
        end
    end

    assign s_tready = ({1'b0, q_cnt_reg} + 3'(s2_fire_reg)) <= 3'd2;
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = q_med_reg[q_head_reg];
    assign m_tlast  = q_last_reg[q_head_reg];

endmodule

`default_nettype wire

@@ rtl/mfrb_checker.sv @@
// ----------------------------------------------------------------------------
// mfrb_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output transaction withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // a result only follows an accepted input transaction
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without an input transaction");

    // input is held off only while results wait in the queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind median_filter_replicate_border mfrb_checker u_mfrb_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire
